>>> rtl/core/vtpc_pkg.sv
// Package with shared constants and types for the version triplet parser.
`timescale 1ns / 1ps

package vtpc_pkg;

	// Width of one parsed component and default component limit.
	localparam int unsigned COMP_W          = 20;
	localparam int unsigned COMPONENT_LIMIT = 1000000;

	// Character codes the parser reacts to.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPPER_V = 8'h56;
	localparam logic [7:0] CHAR_LOWER_V = 8'h76;

	// Ordering codes of the result.
	localparam logic signed [1:0] ORD_LESS    = -2'sd1;
	localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
	localparam logic signed [1:0] ORD_GREATER = 2'sd1;

	// One result as produced by the parse step.
	typedef struct packed {
		logic                    emit;
		logic                    string_id;
		logic                    parse_ok;
		logic [COMP_W-1:0]       major_part;
		logic [COMP_W-1:0]       minor_part;
		logic [COMP_W-1:0]       patch_part;
		logic signed [1:0]       order;
	} result_t;

endpackage

>>> rtl/core/version_triplet_parse_compare.sv
// Top level of the version triplet parser and comparator.
//
// Usage: characters of two NUL-terminated version strings enter on the s_axis
// channel, one per transaction, with tuser telling the first string (0) from
// the second (1). Each string may start with blanks and one v or V, followed by
// major.minor.patch in decimal; text after the patch digits is ignored.
// A result transaction leaves on m_axis only for the NUL of a string. It holds
// validity and the triplet (zeros when invalid) and, for a second string, the
// ordering against the last first string (0 when either is invalid).
// A NUL accepted into the input register passes the parse step and has its result
// loaded into the result register, which drives m_axis_tvalid, once that register
// is free or drains. Throughput: one character per cycle while results are taken.
// When the receiver stalls, the pending result stays in the result register
// and one further character waits in the input register; s_axis_tready then
// falls. Reset clears the parse state, the held first string and all valids.
`timescale 1ns / 1ps

module version_triplet_parse_compare #(
	parameter int unsigned COMPONENT_LIMIT = vtpc_pkg::COMPONENT_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [0] parse_ok, [20:1] major_part,
	                                    // [40:21] minor_part, [60:41] patch_part,
	                                    // [62:61] order, [63] zero
	output logic        m_axis_tuser    // [0] string_id
);

	logic              valid_s1;
	logic              type_s1;
	logic [7:0]        char_s1;
	logic              advance;
	logic              step;
	vtpc_pkg::result_t res;
	logic              out_valid_q;
	logic [63:0]       out_data_q;
	logic              out_user_q;

	// The input register moves on whenever the result register is free or drains.
	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			type_s1 <= s_axis_tuser;
			char_s1 <= s_axis_tdata;
		end
	end

	// Parse step.
	vtpc_parse #(
		.COMPONENT_LIMIT(COMPONENT_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_type  (type_s1),
		.char_byte (char_s1),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			out_user_q <= res.string_id;
			out_data_q <= {1'b0, res.order, res.patch_part, res.minor_part,
			               res.major_part, res.parse_ok};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
	// A nonzero ordering only comes with a valid second string.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[62:61] != 2'b00) |-> m_axis_tdata[0] && m_axis_tuser)
		else $error("ordering reported for a first or invalid string");

	// An invalid string reports an all-zero triplet.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[60:1] == 60'd0))
		else $error("invalid string carries a nonzero triplet");

	// A new result only follows a terminating character in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1 && (char_s1 == vtpc_pkg::CHAR_NUL)))
		else $error("result raised without a terminating character");
`endif

endmodule

>>> rtl/core/vtpc_parse.sv
// Parse state machine, held first triplet and comparison for one character a cycle while step is high.
`timescale 1ns / 1ps

module vtpc_parse #(
	parameter int unsigned COMPONENT_LIMIT = vtpc_pkg::COMPONENT_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               req_type,
	input  logic [7:0]         char_byte,
	output vtpc_pkg::result_t  res
);

	localparam int unsigned ACC_W = vtpc_pkg::COMP_W + 4;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_START,
		PH_DIGITS,
		PH_DONE,
		PH_FAIL
	} phase_t;

	phase_t                      phase_q, phase_nx;
	logic [1:0]                  comp_idx_q, comp_idx_nx;
	logic [vtpc_pkg::COMP_W-1:0] acc_q, acc_nx;
	logic [vtpc_pkg::COMP_W-1:0] major_q, major_nx;
	logic [vtpc_pkg::COMP_W-1:0] minor_q, minor_nx;
	logic                        first_valid_q;
	logic [vtpc_pkg::COMP_W-1:0] first_major_q, first_minor_q, first_patch_q;

	logic                        is_digit;
	logic [3:0]                  digit;
	logic [ACC_W-1:0]            acc_ext, acc_grow, acc_fresh;
	logic                        is_end, ok;
	logic signed [1:0]           ord;

	// Digit decode and the times-ten accumulate.
	always_comb begin
		is_digit  = (char_byte >= vtpc_pkg::CHAR_ZERO) && (char_byte <= vtpc_pkg::CHAR_NINE);
		digit     = is_digit ? 4'(char_byte - vtpc_pkg::CHAR_ZERO) : 4'd0;
		acc_ext   = ACC_W'(acc_q);
		acc_grow  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit);
		acc_fresh = ACC_W'(digit);
	end

	// Next parse state for a nonzero character.
	always_comb begin
		phase_nx    = phase_q;
		comp_idx_nx = comp_idx_q;
		acc_nx      = acc_q;
		major_nx    = major_q;
		minor_nx    = minor_q;
		unique case (phase_q)
			PH_LEAD: begin
				if (char_byte == vtpc_pkg::CHAR_SPACE || char_byte == vtpc_pkg::CHAR_TAB) begin
					phase_nx = PH_LEAD;
				end else if (char_byte == vtpc_pkg::CHAR_LOWER_V ||
				             char_byte == vtpc_pkg::CHAR_UPPER_V) begin
					phase_nx = PH_START;
				end else if (is_digit) begin
					phase_nx = PH_DIGITS;
					acc_nx   = acc_fresh[vtpc_pkg::COMP_W-1:0];
				end else begin
					phase_nx = PH_FAIL;
				end
			end
			PH_START: begin
				if (is_digit) begin
					phase_nx = PH_DIGITS;
					acc_nx   = acc_fresh[vtpc_pkg::COMP_W-1:0];
				end else begin
					phase_nx = PH_FAIL;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					if (acc_grow > ACC_W'(COMPONENT_LIMIT)) begin
						phase_nx = PH_FAIL;
					end else begin
						acc_nx = acc_grow[vtpc_pkg::COMP_W-1:0];
					end
				end else if (comp_idx_q >= 2'd2) begin
					phase_nx = PH_DONE;
				end else if (char_byte == vtpc_pkg::CHAR_DOT) begin
					if (comp_idx_q == 2'd0) begin
						major_nx = acc_q;
					end else begin
						minor_nx = acc_q;
					end
					comp_idx_nx = comp_idx_q + 2'd1;
					phase_nx    = PH_START;
				end else begin
					phase_nx = PH_FAIL;
				end
			end
			PH_DONE: begin
				phase_nx = PH_DONE;
			end
			default: begin
				phase_nx = PH_FAIL;
			end
		endcase
	end

	// Result for a terminating character, with ordering against the held first string.
	always_comb begin
		is_end = (char_byte == vtpc_pkg::CHAR_NUL);
		ok     = (phase_q == PH_DIGITS || phase_q == PH_DONE) && (comp_idx_q == 2'd2);
		ord    = vtpc_pkg::ORD_EQUAL;
		if (req_type && ok && first_valid_q) begin
			priority if (first_major_q < major_q) begin
				ord = vtpc_pkg::ORD_LESS;
			end else if (first_major_q > major_q) begin
				ord = vtpc_pkg::ORD_GREATER;
			end else if (first_minor_q < minor_q) begin
				ord = vtpc_pkg::ORD_LESS;
			end else if (first_minor_q > minor_q) begin
				ord = vtpc_pkg::ORD_GREATER;
			end else if (first_patch_q < acc_q) begin
				ord = vtpc_pkg::ORD_LESS;
			end else if (first_patch_q > acc_q) begin
				ord = vtpc_pkg::ORD_GREATER;
			end else begin
				ord = vtpc_pkg::ORD_EQUAL;
			end
		end
		res.emit       = is_end;
		res.string_id  = req_type;
		res.parse_ok   = ok;
		res.major_part = ok ? major_q : '0;
		res.minor_part = ok ? minor_q : '0;
		res.patch_part = ok ? acc_q : '0;
		res.order      = ord;
	end

	// Parse state and held first triplet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			comp_idx_q    <= 2'd0;
			acc_q         <= '0;
			major_q       <= '0;
			minor_q       <= '0;
			first_valid_q <= 1'b0;
			first_major_q <= '0;
			first_minor_q <= '0;
			first_patch_q <= '0;
		end else if (step) begin
			if (is_end) begin
				phase_q    <= PH_LEAD;
				comp_idx_q <= 2'd0;
				acc_q      <= '0;
				major_q    <= '0;
				minor_q    <= '0;
				if (!req_type) begin
					first_valid_q <= ok;
					first_major_q <= res.major_part;
					first_minor_q <= res.minor_part;
					first_patch_q <= res.patch_part;
				end
			end else begin
				phase_q    <= phase_nx;
				comp_idx_q <= comp_idx_nx;
				acc_q      <= acc_nx;
				major_q    <= major_nx;
				minor_q    <= minor_nx;
			end
		end
	end

endmodule
